// ===== rtl/core/tdpc_pkg.sv =====
package tdpc_pkg;

	localparam int DATA_W = 8;
	localparam int IDX_W  = 3;
	localparam int SHAPE_W = 2;

	localparam logic [SHAPE_W-1:0] SHAPE_RESET = 2'd2;

	localparam logic [0:0] ACT_ENCODE = 1'b0;
	localparam logic [0:0] ACT_DECODE = 1'b1;

	// used column / row parity bits per shape code (C = 1 << code, R = 8 >> code)
	localparam logic [DATA_W-1:0] COL_MASK [4] = '{8'h01, 8'h03, 8'h0f, 8'hff};
	localparam logic [DATA_W-1:0] ROW_MASK [4] = '{8'hff, 8'h0f, 8'h03, 8'h01};

	typedef struct packed {
		logic bit_corrected;
		logic error_detected;
	} tdpc_flags_t;

endpackage

// ===== rtl/core/two_dimensional_parity_codec_core.sv =====
// Two-dimensional parity encoder / single-bit corrector for one byte per beat.
// Pipeline: input register, then result register.
// Throughput: one beat per cycle while the output is not stalled; parity and correction fit between the two registers.
// Reset (arst_n low, asynchronous): pipeline emptied, shape register back to 4 columns x 2 rows.
module two_dimensional_parity_codec_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // data_bits[7:0], column_parity_in[15:8], row_parity_in[23:16]
	input  logic        s_axis_tuser,  // action
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // data_out[7:0], column_parity_out[15:8], row_parity_out[23:16]
	output logic [1:0]  m_axis_tuser,  // error_detected[0], bit_corrected[1]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data       // column_count_log2
);
	import tdpc_pkg::*;

	logic [SHAPE_W-1:0] shape_q;

	logic              v_s1;
	logic              action_s1;
	logic [DATA_W-1:0] data_s1;
	logic [DATA_W-1:0] colp_s1;
	logic [DATA_W-1:0] rowp_s1;
	logic              last_s1;

	logic              v_s2;
	logic [23:0]       tdata_s2;
	tdpc_flags_t       flags_s2;
	logic              last_s2;

	logic              adv;
	logic              in_beat;
	logic [DATA_W-1:0] data_c;
	logic [DATA_W-1:0] colp_c;
	logic [DATA_W-1:0] rowp_c;
	tdpc_flags_t       flags_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= SHAPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			shape_q <= cfg_data;
		end
	end

	// result register moves when empty or drained this cycle
	assign adv           = !v_s2 || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			action_s1 <= s_axis_tuser;
			data_s1   <= s_axis_tdata[7:0];
			colp_s1   <= s_axis_tdata[15:8];
			rowp_s1   <= s_axis_tdata[23:16];
			last_s1   <= s_axis_tlast;
		end
	end

	tdpc_calc u_calc (
		.shape             (shape_q),
		.action            (action_s1),
		.data_bits         (data_s1),
		.column_parity_in  (colp_s1),
		.row_parity_in     (rowp_s1),
		.data_out          (data_c),
		.column_parity_out (colp_c),
		.row_parity_out    (rowp_c),
		.flags             (flags_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			tdata_s2 <= {rowp_c, colp_c, data_c};
			flags_s2 <= flags_c;
			last_s2  <= last_s1;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = tdata_s2;
	assign m_axis_tuser  = {flags_s2.bit_corrected, flags_s2.error_detected};
	assign m_axis_tlast  = last_s2;

`ifndef SYNTHESIS
	a_corr_implies_det: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (!flags_s2.bit_corrected || flags_s2.error_detected))
		else $error("correction flagged without detection");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && !m_axis_tready))
		else $error("input stalled while pipeline has room");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv) |=> v_s2)
		else $error("beat lost between input and result register");
`endif

endmodule

// ===== rtl/core/tdpc_calc.sv =====
module tdpc_calc (
	input  logic [1:0]            shape,
	input  logic                  action,
	input  logic [7:0]            data_bits,
	input  logic [7:0]            column_parity_in,
	input  logic [7:0]            row_parity_in,
	output logic [7:0]            data_out,
	output logic [7:0]            column_parity_out,
	output logic [7:0]            row_parity_out,
	output tdpc_pkg::tdpc_flags_t flags
);
	import tdpc_pkg::*;

	logic [IDX_W-1:0]  col_sel_mask;
	logic [DATA_W-1:0] cpar;
	logic [DATA_W-1:0] rpar;
	logic [DATA_W-1:0] cdiff;
	logic [DATA_W-1:0] rdiff;
	logic [IDX_W-1:0]  err_col;
	logic [IDX_W-1:0]  err_row;
	logic [IDX_W-1:0]  err_pos;
	logic              both_bad;

	assign col_sel_mask = IDX_W'((4'd1 << shape) - 4'd1);

	// bit p: column = p & (C-1), row = p >> log2(C)
	always_comb begin
		cpar = '0;
		rpar = '0;
		for (int p = 0; p < DATA_W; p++) begin
			cpar[IDX_W'(p) & col_sel_mask] = cpar[IDX_W'(p) & col_sel_mask] ^ data_bits[p];
			rpar[IDX_W'(p) >> shape]       = rpar[IDX_W'(p) >> shape] ^ data_bits[p];
		end
	end

	assign cdiff = (cpar ^ column_parity_in) & COL_MASK[shape];
	assign rdiff = (rpar ^ row_parity_in) & ROW_MASK[shape];

	// lowest mismatching column and row
	always_comb begin
		err_col = '0;
		err_row = '0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (cdiff[i]) begin
				err_col = IDX_W'(i);
			end
			if (rdiff[i]) begin
				err_row = IDX_W'(i);
			end
		end
	end

	// err_row * C stays below 8, so the shift fits the index width
	assign err_pos  = IDX_W'(err_row << shape) | err_col;
	assign both_bad = (action == ACT_DECODE) && (cdiff != '0) && (rdiff != '0);

	always_comb begin
		data_out = data_bits;
		if (both_bad) begin
			data_out[err_pos] = ~data_bits[err_pos];
		end
	end

	assign column_parity_out    = cpar;
	assign row_parity_out       = rpar;
	assign flags.error_detected = (action == ACT_DECODE) && ((cdiff != '0) || (rdiff != '0));
	assign flags.bit_corrected  = both_bad;

endmodule

// ===== dv/tdpc_checker.sv =====
module tdpc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // data_bits[7:0], column_parity_in[15:8], row_parity_in[23:16]
	input  logic        s_axis_tuser,  // action
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,  // data_out[7:0], column_parity_out[15:8], row_parity_out[23:16]
	input  logic [1:0]  m_axis_tuser,  // error_detected[0], bit_corrected[1]
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import tdpc_pkg::*;

	// same layout as {tlast, tuser, tdata} on the output side
	typedef struct packed {
		logic              last;
		tdpc_flags_t       flags;
		logic [DATA_W-1:0] row_par;
		logic [DATA_W-1:0] col_par;
		logic [DATA_W-1:0] data;
	} codec_word_t;

	codec_word_t         awaited_words[$];
	logic [SHAPE_W-1:0]  shape;

	function automatic codec_word_t predict_codeword(input logic [SHAPE_W-1:0] code,
			input logic act, input logic [7:0] d, input logic [7:0] rx_col,
			input logic [7:0] rx_row, input logic lst);
		codec_word_t w;
		logic [7:0] cdiff, rdiff, cmask, rmask;
		int cols, rows, ec, er;
		cols = 1 << code;
		rows = 8 >> code;
		cmask = 8'((1 << cols) - 1);
		rmask = 8'((1 << rows) - 1);
		w = '0;
		w.data = d;
		w.last = lst;
		for (int p = 0; p < 8; p++) begin
			w.col_par[p % cols] ^= d[p];
			w.row_par[p / cols] ^= d[p];
		end
		if (act == ACT_DECODE) begin
			cdiff = (w.col_par ^ rx_col) & cmask;
			rdiff = (w.row_par ^ rx_row) & rmask;
			w.flags.error_detected = (cdiff != 0) || (rdiff != 0);
			if (cdiff != 0 && rdiff != 0) begin
				ec = 0;
				er = 0;
				// scan downward so the lowest mismatch wins
				for (int i = 7; i >= 0; i--) begin
					if (cdiff[i]) ec = i;
					if (rdiff[i]) er = i;
				end
				w.data[er * cols + ec] ^= 1'b1;
				w.flags.bit_corrected = 1'b1;
			end
		end
		return w;
	endfunction

	function automatic int field_differs(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		codec_word_t got, want;
		int bad;
		if (!arst_n) begin
			shape <= SHAPE_RESET;
			awaited_words.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready)
				shape <= cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				awaited_words.push_back(predict_codeword(shape, s_axis_tuser,
					s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
					s_axis_tlast));
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
				if (awaited_words.size() == 0) begin
					$display("%0t: unexpected beat: expected none, got %h", $time, got);
					bad = 1;
				end else begin
					want = awaited_words.pop_front();
					bad += field_differs("data_out", want.data, got.data);
					bad += field_differs("column_parity_out", want.col_par, got.col_par);
					bad += field_differs("row_parity_out", want.row_par, got.row_par);
					bad += field_differs("error_detected", 8'(want.flags.error_detected),
						8'(got.flags.error_detected));
					bad += field_differs("bit_corrected", 8'(want.flags.bit_corrected),
						8'(got.flags.bit_corrected));
					bad += field_differs("last_out", 8'(want.last), 8'(got.last));
				end
			end
			mismatches <= mismatches + bad;
			outstanding <= awaited_words.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tdpc_pkg::*;

	localparam int IDLE_LIMIT = 200;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // data_bits[7:0], column_parity_in[15:8], row_parity_in[23:16]
	logic        s_axis_tuser;  // action
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // data_out[7:0], column_parity_out[15:8], row_parity_out[23:16]
	logic [1:0]  m_axis_tuser;  // error_detected[0], bit_corrected[1]
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_data;

	int                  mismatches;
	int                  outstanding;
	int                  idle_cycles;
	int                  hold_left;
	bit                  steady;
	logic [SHAPE_W-1:0]  shape;

	two_dimensional_parity_codec_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	tdpc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always #6 clk = ~clk;

	// sink: after a beat, tready may drop low at random for a randomly drawn hold; never while steady
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b1;
			hold_left <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			hold_left <= steady ? 0 : $urandom_range(0, 4);
			if (!steady && $urandom_range(0, 1))
				m_axis_tready <= 1'b0;
		end else if (!m_axis_tready) begin
			if (hold_left <= 1)
				m_axis_tready <= 1'b1;
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// {row parity, column parity} of a clean codeword
	function automatic logic [15:0] parity_of(input logic [SHAPE_W-1:0] code,
			input logic [7:0] d);
		logic [7:0] c, r;
		int cols;
		c = '0;
		r = '0;
		cols = 1 << code;
		for (int p = 0; p < 8; p++) begin
			c[p % cols] ^= d[p];
			r[p / cols] ^= d[p];
		end
		return {r, c};
	endfunction

	task automatic send_beat(input logic act, input logic [7:0] d, input logic [7:0] c,
			input logic [7:0] r, input logic lst);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {r, c, d};
		s_axis_tuser <= act;
		s_axis_tlast <= lst;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drain the pipeline, then load a new shape
	task automatic set_shape(input logic [SHAPE_W-1:0] code);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= code;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shape = code;
	endtask

	task automatic directed_beats();
		logic [15:0] cw;
		logic [7:0] cmask, rmask;
		int rows;
		rows = 8 >> shape;
		cmask = 8'((1 << (1 << shape)) - 1);
		rmask = 8'((1 << rows) - 1);
		send_beat(ACT_ENCODE, 8'hff, 8'hff, 8'hff, 1'b1);
		// clean word, unused parity bits set high
		cw = parity_of(shape, 8'h00);
		send_beat(ACT_DECODE, 8'h00, cw[7:0] | ~cmask, cw[15:8] | ~rmask, 1'b0);
		// top data bit hit
		cw = parity_of(shape, 8'ha5);
		send_beat(ACT_DECODE, 8'h25, cw[7:0], cw[15:8], 1'b0);
		// column parity alone is off
		cw = parity_of(shape, 8'h3c);
		send_beat(ACT_DECODE, 8'h3c, cw[7:0] ^ 8'h01, cw[15:8], 1'b0);
		// row parity alone is off
		cw = parity_of(shape, 8'hc3);
		send_beat(ACT_DECODE, 8'hc3, cw[7:0], cw[15:8] ^ 8'(1 << (rows - 1)), 1'b0);
		// every parity bit wrong
		cw = parity_of(shape, 8'h96);
		send_beat(ACT_DECODE, 8'h96, ~cw[7:0], ~cw[15:8], 1'b1);
	endtask

	task automatic random_beat();
		logic [15:0] cw;
		logic [7:0] d, c, r, cmask, rmask;
		logic act;
		int cols, rows, kind;
		cols = 1 << shape;
		rows = 8 >> shape;
		cmask = 8'((1 << cols) - 1);
		rmask = 8'((1 << rows) - 1);
		d = 8'($urandom);
		cw = parity_of(shape, d);
		c = cw[7:0];
		r = cw[15:8];
		kind = $urandom_range(0, 11);
		act = (kind < 3) ? ACT_ENCODE : ACT_DECODE;
		case (kind)
			3: ;
			4, 5, 6: d ^= 8'(1 << $urandom_range(0, 7));
			7: c ^= 8'(1 << $urandom_range(0, cols - 1));
			8: r ^= 8'(1 << $urandom_range(0, rows - 1));
			9: d ^= 8'(1 << $urandom_range(0, 7)) ^ 8'(1 << $urandom_range(0, 7));
			default: begin
				c = 8'($urandom);
				r = 8'($urandom);
			end
		endcase
		if ($urandom_range(0, 1)) begin
			c = (c & cmask) | (8'($urandom) & ~cmask);
			r = (r & rmask) | (8'($urandom) & ~rmask);
		end
		send_beat(act, d, c, r, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		logic [SHAPE_W-1:0] directed_shapes[3];
		logic [SHAPE_W-1:0] random_shapes[8];
		directed_shapes = '{2'd0, 2'd3, 2'd1};
		random_shapes = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2};
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_cycles = 0;
		steady = 1'b0;
		shape = SHAPE_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_beats();
		foreach (directed_shapes[i]) begin
			set_shape(directed_shapes[i]);
			directed_beats();
		end

		foreach (random_shapes[i]) begin
			set_shape(random_shapes[i]);
			steady = (i == 2 || i == 5);
			repeat (75) random_beat();
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
